/* rtl/core/clqm_pkg.sv */
// Shared request codes and controller/datapath interface types for the queue manager.
package clqm_pkg;

  // Pool and queue counts fixed by the field widths of the stream words
  localparam int NODES  = 16;
  localparam int QUEUES = 4;

  // Request kinds carried on the input side
  localparam logic [1:0] REQ_APPEND = 2'd0;
  localparam logic [1:0] REQ_REMOVE = 2'd1;
  localparam logic [1:0] REQ_SIZE   = 2'd2;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load_req;    // capture an accepted request word
    logic ld_head;     // capture head of the addressed queue, start a walk
    logic rd_tail;     // read the tail link through the head just read
    logic fresh_link;  // append into an empty queue
    logic tail_link;   // append, first half: link the new node to tail and head
    logic ring_link;   // append, second half: point tail and head at the new node
    logic walk;        // step the ring walk
    logic unlink;      // remove the node found by the walk
    logic ld_result;   // load the output word
    logic res_fail;    // status of the loaded word
    logic res_count;   // report the walk length as count
  } clqm_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic [1:0] kind;     // captured request kind
    logic       bad_req;  // unknown kind, queue or node out of range
    logic       linked;   // addressed node is in some queue
    logic       nonempty; // addressed queue holds a node
    logic       stop;     // walk wrapped around or hit the bound
    logic       hit;      // walk stands on the addressed node
  } clqm_stat_t;

endpackage

/* rtl/core/clqm_ctrl.sv */
// Controller state machine for the queue manager: sequences lookups, walks and link updates.
module clqm_ctrl import clqm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  output logic       m_tvalid,
  input  logic       m_tready,
  input  clqm_stat_t stat,
  output clqm_cmd_t  cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CHECK  = 4'd1;
  localparam logic [3:0] S_HEAD   = 4'd2;
  localparam logic [3:0] S_WALK   = 4'd3;
  localparam logic [3:0] S_UNLINK = 4'd4;
  localparam logic [3:0] S_A_HEAD = 4'd5;
  localparam logic [3:0] S_A_TAIL = 4'd6;
  localparam logic [3:0] S_A_LINK = 4'd7;
  localparam logic [3:0] S_FINISH = 4'd8;

  logic [3:0] state, state_next;
  logic       fail, fail_next;
  logic       use_count, use_count_next;
  logic       out_valid;
  logic       s_accept;

  assign s_tready = (state == S_IDLE);
  assign s_accept = s_tvalid && s_tready;
  assign m_tvalid = out_valid;

  // Next state and commands
  always_comb begin
    state_next     = state;
    fail_next      = fail;
    use_count_next = use_count;
    cmd            = '0;
    cmd.res_fail   = fail;
    cmd.res_count  = use_count;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.load_req = 1'b1;
          state_next   = S_CHECK;
        end
      end
      S_CHECK: begin
        fail_next      = 1'b1;
        use_count_next = 1'b0;
        state_next     = S_FINISH;
        priority if (stat.bad_req) begin
          fail_next = 1'b1;
        end else if (stat.kind == REQ_APPEND) begin
          if (!stat.linked && !stat.nonempty) begin
            cmd.fresh_link = 1'b1;
            fail_next      = 1'b0;
          end else if (!stat.linked) begin
            state_next = S_A_HEAD;
          end
        end else if (stat.kind == REQ_REMOVE) begin
          if (stat.linked && stat.nonempty) begin
            state_next = S_HEAD;
          end
        end else if (stat.kind == REQ_SIZE) begin
          fail_next = 1'b0;
          if (stat.nonempty) begin
            state_next = S_HEAD;
          end
        end else begin
          fail_next = 1'b1;
        end
      end
      S_HEAD: begin
        cmd.ld_head = 1'b1;
        state_next  = S_WALK;
      end
      S_WALK: begin
        cmd.walk = 1'b1;
        if (stat.stop) begin
          fail_next      = (stat.kind != REQ_SIZE);
          use_count_next = (stat.kind == REQ_SIZE);
          state_next     = S_FINISH;
        end else if (stat.hit && (stat.kind == REQ_REMOVE)) begin
          state_next = S_UNLINK;
        end
      end
      S_UNLINK: begin
        cmd.unlink = 1'b1;
        fail_next  = 1'b0;
        state_next = S_FINISH;
      end
      S_A_HEAD: begin
        cmd.ld_head = 1'b1;
        cmd.rd_tail = 1'b1;
        state_next  = S_A_TAIL;
      end
      S_A_TAIL: begin
        cmd.tail_link = 1'b1;
        state_next    = S_A_LINK;
      end
      S_A_LINK: begin
        cmd.ring_link = 1'b1;
        fail_next     = 1'b0;
        state_next    = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid || m_tready) begin
          cmd.ld_result = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State and pending result flags
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fail      <= 1'b0;
      use_count <= 1'b0;
    end else begin
      state     <= state_next;
      fail      <= fail_next;
      use_count <= use_count_next;
    end
  end

  // Hold the output word until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.ld_result) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_accept |=> !s_tready)
    else $error("new request taken while one is in progress");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH && (!out_valid || m_tready)) |=> (out_valid && s_tready))
    else $error("finished request did not reach the output word");

  a_unlink_after_walk: assert property (@(posedge clk) disable iff (rst)
    (state == S_UNLINK) |-> ($past(state) == S_WALK && stat.kind == REQ_REMOVE))
    else $error("unlink reached without a remove walk");

endmodule

/* rtl/core/clqm_dpath.sv */
// Datapath for the queue manager: link memories, head memory, flags, walk pointer and result word.
module clqm_dpath import clqm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic [1:0] req_type,
  input  logic [1:0] queue_id,
  input  logic [3:0] node,
  input  clqm_cmd_t  cmd,
  output clqm_stat_t stat,
  output logic       status,
  output logic [4:0] count
);

  localparam int NW = $clog2(NODES);
  localparam int QW = (QUEUES > 1) ? $clog2(QUEUES) : 1;
  localparam int SW = $clog2(NODES + 1);

  logic [1:0]        req_r;
  logic [1:0]        qid_r;
  logic [3:0]        node_r;
  logic [NW-1:0]     n_idx;
  logic [QW-1:0]     q_idx;

  logic [NODES-1:0]  linked;
  logic [QUEUES-1:0] nonempty;

  logic [NW-1:0]     next_mem [NODES];
  logic [NW-1:0]     prev_mem [NODES];
  logic [NW-1:0]     head_mem [QUEUES];
  logic [NW-1:0]     next_rd, prev_rd, head_rd;

  logic [NW-1:0]     h_reg, t_reg, cur;
  logic              first;
  logic [SW-1:0]     steps;
  logic              single;

  logic              nx_we, pv_we, hd_we;
  logic [NW-1:0]     nx_waddr, nx_wdata, pv_waddr, pv_wdata, pv_raddr, hd_wdata;

  assign n_idx = NW'(node_r);
  assign q_idx = QW'(qid_r);

  // Capture the request word
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_r  <= req_type;
      qid_r  <= queue_id;
      node_r <= node;
    end
  end

  // Walk pointer: head while the first flag is set, then the link just read
  assign cur    = first ? h_reg : next_rd;
  assign single = (next_rd == n_idx);

  // Decode for the controller
  always_comb begin
    stat.kind     = req_r;
    stat.bad_req  = (32'(qid_r) >= QUEUES) ||
                    (req_r != REQ_APPEND && req_r != REQ_REMOVE && req_r != REQ_SIZE) ||
                    ((req_r != REQ_SIZE) && (32'(node_r) >= NODES));
    stat.linked   = linked[n_idx];
    stat.nonempty = nonempty[q_idx];
    stat.stop     = (steps == SW'(NODES)) || (!first && (cur == h_reg));
    stat.hit      = (cur == n_idx);
  end

  // Next-link write port
  always_comb begin
    nx_we    = 1'b0;
    nx_waddr = n_idx;
    nx_wdata = n_idx;
    priority if (cmd.fresh_link) begin
      nx_we = 1'b1;
    end else if (cmd.tail_link) begin
      nx_we    = 1'b1;
      nx_wdata = h_reg;
    end else if (cmd.ring_link) begin
      nx_we    = 1'b1;
      nx_waddr = t_reg;
    end else if (cmd.unlink) begin
      nx_we    = !single;
      nx_waddr = prev_rd;
      nx_wdata = next_rd;
    end
  end

  // Prev-link write port and read address
  always_comb begin
    pv_we    = 1'b0;
    pv_waddr = n_idx;
    pv_wdata = n_idx;
    pv_raddr = cmd.rd_tail ? head_rd : n_idx;
    priority if (cmd.fresh_link) begin
      pv_we = 1'b1;
    end else if (cmd.tail_link) begin
      pv_we    = 1'b1;
      pv_wdata = prev_rd;
    end else if (cmd.ring_link) begin
      pv_we    = 1'b1;
      pv_waddr = h_reg;
    end else if (cmd.unlink) begin
      pv_we    = !single;
      pv_waddr = next_rd;
      pv_wdata = prev_rd;
    end
  end

  // Head write port: new head on fresh append, or successor when the head leaves
  always_comb begin
    hd_we    = cmd.fresh_link || (cmd.unlink && !single && (n_idx == h_reg));
    hd_wdata = cmd.fresh_link ? n_idx : next_rd;
  end

  // Link and head memories
  always_ff @(posedge clk) begin
    if (nx_we) begin
      next_mem[nx_waddr] <= nx_wdata;
    end
    next_rd <= next_mem[cur];
  end

  always_ff @(posedge clk) begin
    if (pv_we) begin
      prev_mem[pv_waddr] <= pv_wdata;
    end
    prev_rd <= prev_mem[pv_raddr];
  end

  always_ff @(posedge clk) begin
    if (hd_we) begin
      head_mem[q_idx] <= hd_wdata;
    end
    head_rd <= head_mem[q_idx];
  end

  // Linked and nonempty flags
  always_ff @(posedge clk) begin
    if (rst) begin
      linked   <= '0;
      nonempty <= '0;
    end else begin
      if (cmd.fresh_link) begin
        linked[n_idx]   <= 1'b1;
        nonempty[q_idx] <= 1'b1;
      end
      if (cmd.ring_link) begin
        linked[n_idx] <= 1'b1;
      end
      if (cmd.unlink) begin
        linked[n_idx] <= 1'b0;
        if (single) begin
          nonempty[q_idx] <= 1'b0;
        end
      end
    end
  end

  // Walk state: head, first flag, visited count
  always_ff @(posedge clk) begin
    if (rst) begin
      first <= 1'b0;
      steps <= '0;
    end else if (cmd.ld_head) begin
      first <= 1'b1;
      steps <= '0;
    end else if (cmd.walk) begin
      first <= 1'b0;
      if (!stat.stop) begin
        steps <= steps + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_head) begin
      h_reg <= head_rd;
    end
    if (cmd.tail_link) begin
      t_reg <= prev_rd;
    end
  end

  // Output word
  always_ff @(posedge clk) begin
    if (cmd.ld_result) begin
      status <= cmd.res_fail;
      count  <= cmd.res_count ? 5'(steps) : 5'd0;
    end
  end

  a_steps_bound: assert property (@(posedge clk) disable iff (rst)
    32'(steps) <= NODES)
    else $error("walk visited more nodes than the pool holds");

  a_unlink_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.unlink |=> !linked[n_idx])
    else $error("removed node still marked linked");

  a_append_sets: assert property (@(posedge clk) disable iff (rst)
    (cmd.fresh_link || cmd.ring_link) |=> (linked[n_idx] && nonempty[q_idx]))
    else $error("appended node or its queue not marked");

endmodule

/* rtl/core/circular_linked_queue_manager.sv */
// Path from accept to result word: the check alone settles a failure, an append into an empty
// queue and a size of an empty queue; an append behind an existing tail reads head and tail,
// links the new node, closes the ring; remove and size load the head and walk the ring (one
// next-link memory read per cycle, up to NODES nodes). One request is in progress at a time;
// the next is taken once the result word loads, and the output word holds while a new one is taken.
// Synchronous reset clears all link flags and queue flags at once; no clearing pass.
module circular_linked_queue_manager import clqm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [1:0] queue_id, [5:2] node, [7:6] zero
  input  logic [1:0] s_tuser,   // [1:0] req_type
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata    // [0] status, [5:1] count, [7:6] zero
);

  clqm_cmd_t  cmd;
  clqm_stat_t stat;
  logic       status;
  logic [4:0] count;

  clqm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  clqm_dpath u_dpath (
    .clk      (clk),
    .rst      (rst),
    .req_type (s_tuser),
    .queue_id (s_tdata[1:0]),
    .node     (s_tdata[5:2]),
    .cmd      (cmd),
    .stat     (stat),
    .status   (status),
    .count    (count)
  );

  // Pack the result word
  assign m_tdata = {2'b00, count, status};

endmodule
